### design/rqs_pkg.sv
// Shared types, constants and codes for the request queue scheduler.
`default_nettype none
package rqs_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int HANDLE_W   = 16;
  localparam int SIZE_W     = 32;
  localparam int ENTRY_W    = HANDLE_W + SIZE_W;
  localparam int OCC_W      = 5;
  localparam int POLICY_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int LFSR_W     = 16;
  localparam int LFSR_BIT_W = $clog2(LFSR_W);
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  typedef enum logic [POLICY_W-1:0] {
    POLICY_OLDEST   = 2'd0,
    POLICY_SMALLEST = 2'd1,
    POLICY_RANDOM   = 2'd2
  } policy_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MOD,
    ST_FETCH,
    ST_TAKE,
    ST_SHIFT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic    load_in;
    logic    enq_write;
    logic    set_status;
    status_e status;
    logic    scan_start;
    logic    scan_step;
    logic    mod_start;
    logic    mod_step;
    logic    pick_zero;
    logic    fetch;
    logic    take;
    logic    shift;
    logic    count_dec;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    mode_e               mode;
    logic                full;
    logic                empty;
    logic [POLICY_W-1:0] policy;
    logic                scan_last;
    logic                mod_last;
    logic                no_move;
    logic                shift_last;
    logic                out_free;
  } sts_t;

endpackage
`default_nettype wire

### design/rqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/rqs_ctrl.sv
// Control state machine that sequences enqueue, selection, compaction and result.
`default_nettype none
module rqs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rqs_pkg::sts_t sts_i,
  output rqs_pkg::cmd_t      cmd_o
);

  rqs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rqs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.status  = rqs_pkg::STATUS_DONE;
    in_stall_o    = 1'b1;
    unique case (state_q)
      rqs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = rqs_pkg::ST_DECODE;
        end
      end
      rqs_pkg::ST_DECODE: begin
        if (sts_i.mode == rqs_pkg::MODE_ENQ) begin
          if (sts_i.full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = rqs_pkg::STATUS_FULL;
          end else begin
            cmd_o.enq_write = 1'b1;
          end
          state_d = rqs_pkg::ST_FINISH;
        end else if (sts_i.empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = rqs_pkg::STATUS_EMPTY;
          state_d          = rqs_pkg::ST_FINISH;
        end else begin
          unique case (sts_i.policy)
            rqs_pkg::POLICY_SMALLEST: begin
              cmd_o.scan_start = 1'b1;
              state_d          = rqs_pkg::ST_SCAN;
            end
            rqs_pkg::POLICY_RANDOM: begin
              cmd_o.mod_start = 1'b1;
              state_d         = rqs_pkg::ST_MOD;
            end
            default: begin
              cmd_o.pick_zero = 1'b1;
              state_d         = rqs_pkg::ST_FETCH;
            end
          endcase
        end
      end
      rqs_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = rqs_pkg::ST_FETCH;
        end
      end
      rqs_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = rqs_pkg::ST_FETCH;
        end
      end
      rqs_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = rqs_pkg::ST_TAKE;
      end
      rqs_pkg::ST_TAKE: begin
        cmd_o.take = 1'b1;
        if (sts_i.no_move) begin
          cmd_o.count_dec = 1'b1;
          state_d         = rqs_pkg::ST_FINISH;
        end else begin
          state_d = rqs_pkg::ST_SHIFT;
        end
      end
      rqs_pkg::ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_last) begin
          cmd_o.count_dec = 1'b1;
          state_d         = rqs_pkg::ST_FINISH;
        end
      end
      rqs_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = rqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rqs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/rqs_dp.sv
// Datapath: entry store, count, policy, LFSR, modulo unit, minimum scan and result register.
`default_nettype none
module rqs_dp #(
  parameter int DEPTH = rqs_pkg::DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             policy_we_i,
  input  wire logic [rqs_pkg::POLICY_W-1:0]     policy_i,
  input  wire logic                             mode_i,
  input  wire logic [rqs_pkg::HANDLE_W-1:0]     handle_i,
  input  wire logic [rqs_pkg::SIZE_W-1:0]       req_size_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [rqs_pkg::STATUS_W-1:0]          status_o,
  output logic [rqs_pkg::HANDLE_W-1:0]          out_handle_o,
  output logic [rqs_pkg::SIZE_W-1:0]            out_size_o,
  output logic [rqs_pkg::OCC_W-1:0]             occupancy_o,
  input  wire rqs_pkg::cmd_t                    cmd_i,
  output rqs_pkg::sts_t                         sts_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + 1;
  localparam int HW = rqs_pkg::HANDLE_W;
  localparam int SW = rqs_pkg::SIZE_W;
  localparam int EW = rqs_pkg::ENTRY_W;

  // Control registers.
  logic [CW-1:0]                count_q;
  logic [rqs_pkg::LFSR_W-1:0]   lfsr_q;
  logic [rqs_pkg::POLICY_W-1:0] policy_q;
  logic                         out_valid_q;

  // Working and payload registers.
  rqs_pkg::mode_e                mode_q;
  logic [HW-1:0]                 hdl_q;
  logic [SW-1:0]                 size_q;
  logic [CW-1:0]                 ridx_q;
  logic [AW-1:0]                 cidx_q;
  logic [AW-1:0]                 pick_q;
  logic [SW-1:0]                 best_q;
  logic [CW-1:0]                 rem_q;
  logic [rqs_pkg::LFSR_BIT_W-1:0] bit_q;
  rqs_pkg::status_e              res_status_q;
  logic [HW-1:0]                 res_handle_q;
  logic [SW-1:0]                 res_size_q;
  rqs_pkg::status_e              out_status_q;
  logic [HW-1:0]                 out_handle_q;
  logic [SW-1:0]                 out_size_q;
  logic [rqs_pkg::OCC_W-1:0]     out_occ_q;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [EW-1:0]                ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [EW-1:0]                ram_rdata;
  logic [SW-1:0]                rd_size;
  logic [HW-1:0]                rd_handle;
  logic [CW-1:0]                ridx_dec;
  logic [XW-1:0]                cidx_p1;
  logic [XW-1:0]                cidx_p2;
  logic [XW-1:0]                count_x;
  logic [XW-1:0]                mod_trial;
  logic [CW-1:0]                rem_d;
  logic [rqs_pkg::LFSR_W-1:0]   lfsr_d;
  logic                         lfsr_fb;
  logic                         out_free;

  assign rd_size   = ram_rdata[SW-1:0];
  assign rd_handle = ram_rdata[EW-1:SW];
  assign ridx_dec  = ridx_q - CW'(1);
  assign cidx_p1   = XW'(cidx_q) + XW'(1);
  assign cidx_p2   = XW'(cidx_q) + XW'(2);
  assign count_x   = XW'(count_q);

  assign lfsr_fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
  assign lfsr_d  = {lfsr_fb, lfsr_q[rqs_pkg::LFSR_W-1:1]};

  assign mod_trial = {rem_q, lfsr_q[bit_q]};
  assign rem_d     = (mod_trial >= count_x) ? CW'(mod_trial - count_x) : CW'(mod_trial);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cidx_q;
    ram_wdata = ram_rdata;
    if (cmd_i.enq_write) begin
      ram_we    = 1'b1;
      ram_waddr = count_q[AW-1:0];
      ram_wdata = {hdl_q, size_q};
    end else if (cmd_i.shift) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ram_raddr = '0;
    if (cmd_i.scan_step) begin
      ram_raddr = ridx_q[AW-1:0];
    end else if (cmd_i.fetch) begin
      ram_raddr = pick_q;
    end else if (cmd_i.take) begin
      ram_raddr = cidx_p1[AW-1:0];
    end else if (cmd_i.shift) begin
      ram_raddr = cidx_p2[AW-1:0];
    end
  end

  rqs_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      lfsr_q      <= rqs_pkg::LFSR_SEED;
      policy_q    <= rqs_pkg::POLICY_OLDEST;
      out_valid_q <= 1'b0;
    end else begin
      if (policy_we_i) begin
        policy_q <= policy_i;
      end
      if (cmd_i.enq_write) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.mod_start) begin
        lfsr_q <= lfsr_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q       <= rqs_pkg::mode_e'(mode_i);
      hdl_q        <= handle_i;
      size_q       <= req_size_i;
      res_status_q <= rqs_pkg::STATUS_DONE;
      res_handle_q <= '0;
      res_size_q   <= '0;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.scan_start) begin
      ridx_q <= CW'(1);
    end else if (cmd_i.scan_step) begin
      ridx_q <= ridx_q + CW'(1);
      if (ridx_q == CW'(1) || rd_size < best_q) begin
        best_q <= rd_size;
        pick_q <= ridx_dec[AW-1:0];
      end
    end
    if (cmd_i.mod_start) begin
      rem_q <= '0;
      bit_q <= '1;
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_d;
      bit_q <= bit_q - 1'b1;
      if (bit_q == '0) begin
        pick_q <= rem_d[AW-1:0];
      end
    end
    if (cmd_i.pick_zero) begin
      pick_q <= '0;
    end
    if (cmd_i.fetch) begin
      cidx_q <= pick_q;
    end else if (cmd_i.shift) begin
      cidx_q <= cidx_q + 1'b1;
    end
    if (cmd_i.take) begin
      res_handle_q <= rd_handle;
      res_size_q   <= rd_size;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_size_q   <= res_size_q;
      out_occ_q    <= rqs_pkg::OCC_W'(count_q);
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.mode       = mode_q;
    sts_o.full       = (count_q >= CW'(DEPTH));
    sts_o.empty      = (count_q == '0);
    sts_o.policy     = policy_q;
    sts_o.scan_last  = (ridx_q == count_q);
    sts_o.mod_last   = (bit_q == '0);
    sts_o.no_move    = (cidx_p1 >= count_x);
    sts_o.shift_last = (cidx_p2 >= count_x);
    sts_o.out_free   = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_handle_o = out_handle_q;
  assign out_size_o   = out_size_q;
  assign occupancy_o  = out_occ_q;

endmodule
`default_nettype wire

### design/request_queue_scheduler.sv
// Top level of the request queue scheduler: controller and datapath.
//
//   channel   direction  handshake                 payload
//   config    in         policy_we_i               policy_i
//   request   in         in_valid_i / in_stall_o   mode_i, handle_i, req_size_i
//   result    out        out_valid_o / out_stall_i status_o, out_handle_o, out_size_o,
//                                                  occupancy_o
//
// One beat is taken at a time. A dequeue moves the entries behind the removed one down
// one place, one per cycle through the single RAM write port.
// A smallest-first dequeue first scans the N queued entries, one RAM read each;
// a random dequeue first runs the bit-serial modulo of the LFSR value by N.
// The entry store is not cleared at reset; only the count, LFSR, policy and output valid flag are reset.
// A finished result waits in the output register while the next request beat is taken.
`default_nettype none
module request_queue_scheduler #(
  parameter int DEPTH = rqs_pkg::DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         policy_we_i,
  input  wire logic [rqs_pkg::POLICY_W-1:0] policy_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         mode_i,
  input  wire logic [rqs_pkg::HANDLE_W-1:0] handle_i,
  input  wire logic [rqs_pkg::SIZE_W-1:0]   req_size_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [rqs_pkg::STATUS_W-1:0]      status_o,
  output logic [rqs_pkg::HANDLE_W-1:0]      out_handle_o,
  output logic [rqs_pkg::SIZE_W-1:0]        out_size_o,
  output logic [rqs_pkg::OCC_W-1:0]         occupancy_o
);

  rqs_pkg::cmd_t cmd;
  rqs_pkg::sts_t sts;

  rqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rqs_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .policy_we_i (policy_we_i),
    .policy_i    (policy_i),
    .mode_i      (mode_i),
    .handle_i    (handle_i),
    .req_size_i  (req_size_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .out_handle_o(out_handle_o),
    .out_size_o  (out_size_o),
    .occupancy_o (occupancy_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire
